FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros expect clk in scope; ASSERT_CLK also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, including during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/iefa_pkg.sv
`default_nettype none

package iefa_pkg;

    // Number of codes per event type that the filter tracks
    localparam int NUM_CODES = 64;
    localparam int CODE_W    = $clog2(NUM_CODES);
    // Tick rate of the repeat timer
    localparam int TICK_HZ   = 100;

    // Field widths
    localparam int TYPE_W  = 3;
    localparam int EVCODE_W = 10;
    localparam int VALUE_W = 32;
    localparam int MASK_W  = 64;
    localparam int REP_W   = 16;
    localparam int TDATA_W = 48;

    // Repeat settings after reset
    localparam logic [REP_W-1:0] RPT_DELAY_RST  = REP_W'(TICK_HZ / 4);
    localparam logic [REP_W-1:0] RPT_PERIOD_RST = REP_W'(TICK_HZ / 33);

    // Value carried by an autorepeat key word
    localparam logic [VALUE_W-1:0] KEY_REPEAT_VAL = VALUE_W'(2);

    // Command flag carried in tuser
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Event types
    typedef enum logic [TYPE_W-1:0] {
        EV_KEY = 3'd0,
        EV_REL = 3'd1,
        EV_ABS = 3'd2,
        EV_LED = 3'd3,
        EV_SND = 3'd4,
        EV_REP = 3'd5
    } ev_type_t;

    // Repeat setting codes
    localparam logic [EVCODE_W-1:0] REP_CODE_DELAY  = EVCODE_W'(0);
    localparam logic [EVCODE_W-1:0] REP_CODE_PERIOD = EVCODE_W'(1);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TYPE_EN = 3'd0,
        REG_KEY_EN  = 3'd1,
        REG_REL_EN  = 3'd2,
        REG_ABS_EN  = 3'd3,
        REG_LED_EN  = 3'd4,
        REG_SND_EN  = 3'd5
    } cfg_reg_t;

    // A stored delay or period of zero counts as one tick
    function automatic logic [REP_W-1:0] at_least_one(input logic [REP_W-1:0] v);
        at_least_one = (v == '0) ? REP_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

FILE: src/input_event_filter_autorepeat_core.sv
`default_nettype none

// Input event filter with key autorepeat. Each slave word is an event
// (s_tuser = 0) or a repeat timer tick (s_tuser = 1); a master word is a
// forwarded event, with m_tuser set when it also goes to the device (LED,
// sound, repeat setting). The block takes one word per clock while the
// output register is not stalled by m_tready. A word is held in the input
// register while the absolute-axis value memory is read, then the filter
// decision lands in the output register. Back-to-back events on the same
// axis are covered by a write bypass around that memory read. Dropped events
// and ticks that do not fire produce no master word. The user must write the configuration through
// cfg_we / cfg_index / cfg_data only while the block is idle; the block itself does not enforce this.
module input_event_filter_autorepeat_core
    import iefa_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    // slave side
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [TDATA_W-1:0]   s_tdata,   // event_type[2:0], event_code[12:3], event_value[44:13]
    input  wire                 s_tuser,   // command
    // master side
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // out_type[2:0], out_code[12:3], out_value[44:13]
    output logic                m_tuser,   // to_device
    // configuration
    input  wire                 cfg_we,
    input  wire [2:0]           cfg_index,
    input  wire [MASK_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]        type_en_reg;
    logic [MASK_W-1:0] key_en_reg, rel_en_reg, abs_en_reg, led_en_reg, snd_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_en_reg <= '0;
            key_en_reg  <= '0;
            rel_en_reg  <= '0;
            abs_en_reg  <= '0;
            led_en_reg  <= '0;
            snd_en_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TYPE_EN: type_en_reg <= cfg_data[7:0];
                REG_KEY_EN:  key_en_reg  <= cfg_data;
                REG_REL_EN:  rel_en_reg  <= cfg_data;
                REG_ABS_EN:  abs_en_reg  <= cfg_data;
                REG_LED_EN:  led_en_reg  <= cfg_data;
                REG_SND_EN:  snd_en_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and input register
    // ------------------------------------------------------------------
    logic                stg_vld_reg;
    logic                stg_cmd_reg;
    logic [TYPE_W-1:0]   stg_type_reg;
    logic [EVCODE_W-1:0] stg_code_reg;
    logic [VALUE_W-1:0]  stg_value_reg;
    logic                m_vld_reg;
    logic                proc;
    logic                s_accept;

    logic [EVCODE_W-1:0] s_code;
    assign s_code = s_tdata[12:3];

    // stage word is decided when the output register is free or draining
    assign proc     = stg_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !stg_vld_reg || proc;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_vld_reg <= 1'b0;
        else if (s_tready)
            stg_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            stg_cmd_reg   <= s_tuser;
            stg_type_reg  <= s_tdata[2:0];
            stg_code_reg  <= s_code;
            stg_value_reg <= s_tdata[44:13];
        end
    end

    // ------------------------------------------------------------------
    // Absolute axis value memory with valid bits and write bypass
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0]   abs_mem [NUM_CODES];
    logic [VALUE_W-1:0]   abs_rd_reg;
    logic [NUM_CODES-1:0] abs_vld_reg;
    logic                 rd_vld_reg;
    logic                 byp_reg;
    logic [VALUE_W-1:0]   byp_data_reg;
    logic                 abs_we;
    logic [CODE_W-1:0]    abs_wa;
    logic [VALUE_W-1:0]   abs_old;
    logic                 byp_hit;

    assign byp_hit = abs_we && (abs_wa == s_code[CODE_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (abs_we)
            abs_mem[abs_wa] <= stg_value_reg;
        if (s_accept)
            abs_rd_reg <= abs_mem[s_code[CODE_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            if (abs_we)
                abs_vld_reg[abs_wa] <= 1'b1;
            if (s_accept)
            begin
                rd_vld_reg <= abs_vld_reg[s_code[CODE_W-1:0]];
                byp_reg    <= byp_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            byp_data_reg <= stg_value_reg;
    end

    assign abs_old = byp_reg    ? byp_data_reg :
                     rd_vld_reg ? abs_rd_reg   : '0;

    // ------------------------------------------------------------------
    // Filter state
    // ------------------------------------------------------------------
    logic [NUM_CODES-1:0] key_down_reg, key_down_next;
    logic [NUM_CODES-1:0] led_on_reg, led_on_next;
    logic [NUM_CODES-1:0] snd_on_reg, snd_on_next;
    logic [REP_W-1:0]     rpt_delay_reg, rpt_delay_next;
    logic [REP_W-1:0]     rpt_period_reg, rpt_period_next;
    logic [CODE_W-1:0]    rep_code_reg, rep_code_next;
    logic                 rep_armed_reg, rep_armed_next;
    logic [REP_W-1:0]     rep_count_reg, rep_count_next;

    // ------------------------------------------------------------------
    // Filter decision for the stage word
    // ------------------------------------------------------------------
    logic                eff_active;
    logic [TYPE_W-1:0]   eff_type;
    logic [EVCODE_W-1:0] eff_code;
    logic [VALUE_W-1:0]  eff_value;
    logic [CODE_W-1:0]   cs;
    logic                in_range;
    logic                fwd;
    logic                dev;
    logic [REP_W-1:0]    sat;
    logic                tick;

    assign tick = (stg_cmd_reg == CMD_TICK);

    // a tick that fires becomes a key repeat word for the held key
    always_comb
    begin
        if (tick)
        begin
            eff_active = rep_armed_reg && (rep_count_reg <= REP_W'(1));
            eff_type   = EV_KEY;
            eff_code   = {{(EVCODE_W-CODE_W){1'b0}}, rep_code_reg};
            eff_value  = KEY_REPEAT_VAL;
        end
        else
        begin
            eff_active = 1'b1;
            eff_type   = stg_type_reg;
            eff_code   = stg_code_reg;
            eff_value  = stg_value_reg;
        end
    end

    assign cs       = eff_code[CODE_W-1:0];
    assign in_range = (eff_code < EVCODE_W'(NUM_CODES));

    // repeat setting saturated to 0..65535
    assign sat = eff_value[VALUE_W-1]               ? '0 :
                 (eff_value[VALUE_W-2:REP_W] != '0) ? '1 : eff_value[REP_W-1:0];

    always_comb
    begin
        key_down_next   = key_down_reg;
        led_on_next     = led_on_reg;
        snd_on_next     = snd_on_reg;
        rpt_delay_next  = rpt_delay_reg;
        rpt_period_next = rpt_period_reg;
        rep_code_next   = rep_code_reg;
        rep_armed_next  = rep_armed_reg;
        rep_count_next  = rep_count_reg;
        abs_we          = 1'b0;
        abs_wa          = cs;
        fwd             = 1'b0;
        dev             = 1'b0;

        if (proc)
        begin
            // tick countdown
            if (tick && rep_armed_reg)
            begin
                if (rep_count_reg > REP_W'(1))
                    rep_count_next = rep_count_reg - REP_W'(1);
                else
                    rep_count_next = at_least_one(rpt_period_reg);
            end

            if (eff_active && type_en_reg[eff_type])
            begin
                case (eff_type)
                    EV_KEY:
                    begin
                        if (in_range && key_en_reg[cs] &&
                            ({{(VALUE_W-1){1'b0}}, key_down_reg[cs]} != eff_value))
                        begin
                            fwd = 1'b1;
                            if (eff_value != KEY_REPEAT_VAL)
                            begin
                                key_down_next[cs] = ~key_down_reg[cs];
                                if (type_en_reg[EV_REP])
                                begin
                                    if (eff_value != '0)
                                    begin
                                        rep_count_next = at_least_one(rpt_delay_reg);
                                        rep_armed_next = 1'b1;
                                        rep_code_next  = cs;
                                    end
                                    else if (rep_code_reg == cs)
                                        rep_armed_next = 1'b0;
                                end
                            end
                        end
                    end
                    EV_REL:
                        fwd = in_range && rel_en_reg[cs] && (eff_value != '0);
                    EV_ABS:
                    begin
                        if (in_range && abs_en_reg[cs] && (abs_old != eff_value))
                        begin
                            fwd    = 1'b1;
                            abs_we = 1'b1;
                        end
                    end
                    EV_LED:
                    begin
                        if (in_range && led_en_reg[cs] &&
                            ({{(VALUE_W-1){1'b0}}, led_on_reg[cs]} != eff_value))
                        begin
                            fwd             = 1'b1;
                            dev             = 1'b1;
                            led_on_next[cs] = ~led_on_reg[cs];
                        end
                    end
                    EV_SND:
                    begin
                        if (in_range && snd_en_reg[cs] &&
                            ({{(VALUE_W-1){1'b0}}, snd_on_reg[cs]} != eff_value))
                        begin
                            fwd             = 1'b1;
                            dev             = 1'b1;
                            snd_on_next[cs] = ~snd_on_reg[cs];
                        end
                    end
                    EV_REP:
                    begin
                        if (eff_code == REP_CODE_DELAY && rpt_delay_reg != sat)
                        begin
                            fwd            = 1'b1;
                            dev            = 1'b1;
                            rpt_delay_next = sat;
                        end
                        else if (eff_code == REP_CODE_PERIOD && rpt_period_reg != sat)
                        begin
                            fwd             = 1'b1;
                            dev             = 1'b1;
                            rpt_period_next = sat;
                        end
                    end
                    // other enabled types pass unchanged
                    default:
                        fwd = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg   <= '0;
            led_on_reg     <= '0;
            snd_on_reg     <= '0;
            rpt_delay_reg  <= RPT_DELAY_RST;
            rpt_period_reg <= RPT_PERIOD_RST;
            rep_code_reg   <= '0;
            rep_armed_reg  <= 1'b0;
            rep_count_reg  <= '0;
        end
        else
        begin
            key_down_reg   <= key_down_next;
            led_on_reg     <= led_on_next;
            snd_on_reg     <= snd_on_next;
            rpt_delay_reg  <= rpt_delay_next;
            rpt_period_reg <= rpt_period_next;
            rep_code_reg   <= rep_code_next;
            rep_armed_reg  <= rep_armed_next;
            rep_count_reg  <= rep_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [TYPE_W-1:0]   o_type_reg;
    logic [EVCODE_W-1:0] o_code_reg;
    logic [VALUE_W-1:0]  o_value_reg;
    logic                o_dev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (proc)
            m_vld_reg <= fwd;
        else if (m_tready)
            m_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && fwd)
        begin
            o_type_reg  <= eff_type;
            o_code_reg  <= eff_code;
            o_value_reg <= eff_value;
            o_dev_reg   <= dev;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(TDATA_W-TYPE_W-EVCODE_W-VALUE_W){1'b0}},
                       o_value_reg, o_code_reg, o_type_reg};
    assign m_tuser  = o_dev_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // types that may carry the device flag
    logic out_dev_ok;
    assign out_dev_ok = (o_type_reg inside {EV_LED, EV_SND, EV_REP});

`include "assert_macros.svh"

    `ASSERT_CLK(a_ready_when_out_free, !m_vld_reg |-> s_tready, "input stalled, output free")
    `ASSERT_CLK(a_armed_count_nonzero, rep_armed_reg |-> (rep_count_reg != '0), "zero count")
    `ASSERT_CLK(a_dev_types, (m_vld_reg && o_dev_reg) |-> out_dev_ok, "device flag on wrong type")
    `ASSERT_CLK(a_out_from_stage, $rose(m_vld_reg) |-> $past(proc), "output word without stage")

endmodule

`default_nettype wire
